[hdl/msef_pkg.sv]
package msef_pkg;

  localparam int COL_W      = 10;
  localparam int ROW_W      = 5;
  localparam int CH_W       = 8;
  localparam int CH_MAX     = (1 << CH_W) - 1;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int TW_REG_W   = 11;
  localparam int TH_REG_W   = 6;
  localparam int WW_REG_W   = 10;

  localparam int DEF_MAX_TEXT_WIDTH  = 1024;
  localparam int DEF_MAX_TEXT_HEIGHT = 32;
  localparam int DEF_FADE_WIDTH      = 24;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_RED     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_GREEN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_BLUE    = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic [CH_W-1:0]  in_red;
    logic [CH_W-1:0]  in_green;
    logic [CH_W-1:0]  in_blue;
  } item_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
  } result_t;

  typedef struct packed {
    logic [TW_REG_W-1:0] text_width;
    logic [TH_REG_W-1:0] text_height;
    logic [WW_REG_W-1:0] window_width;
    logic [CH_W-1:0]     fade_red;
    logic [CH_W-1:0]     fade_green;
    logic [CH_W-1:0]     fade_blue;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    text_width:   11'd1024,
    text_height:  6'd32,
    window_width: 10'd100,
    fade_red:     8'd255,
    fade_green:   8'd255,
    fade_blue:    8'd255
  };

  // queue entry, fixed part
  typedef struct packed {
    logic             is_write;
    logic             ok;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic [3*CH_W-1:0] pixel;
  } q_item_t;

  function automatic int sum_width(int max_w);
    int sw;
    sw = $clog2(max_w);
    return ((sw > COL_W) ? sw : COL_W) + 1;
  endfunction

endpackage

[hdl/marquee_scroll_edge_fade.sv]
// a read gives its result after the queue, the modulo stages, the pixel memory read and
//   the blend stages; writes and ticks give none
// throughput: one item per cycle unless a full queue or a result stall holds it back,
//   set by the one pixel memory access each item uses; a tick that finds the scroll
//   column beyond a shrunk text width is stalled while the front divider reduces it
// reset: synchronous; clears configuration, scroll state and pipeline, not the pixel memory
module marquee_scroll_edge_fade import msef_pkg::*; #(
  parameter int MAX_TEXT_WIDTH  = DEF_MAX_TEXT_WIDTH,
  parameter int MAX_TEXT_HEIGHT = DEF_MAX_TEXT_HEIGHT,
  parameter int FADE_WIDTH      = DEF_FADE_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int TW_W    = $clog2(MAX_TEXT_WIDTH) + 1;
  localparam int SUM_W   = sum_width(MAX_TEXT_WIDTH);
  localparam int Q_W     = $bits(q_item_t) + SUM_W;
  localparam int Q_DEPTH = 4;

  cfg_t              cfg;
  logic [TW_W-1:0]   tw_eff;
  logic              f_push;
  q_item_t           f_item;
  logic [SUM_W-1:0]  f_sum;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;
  logic [Q_W-1:0]    q_rdata;
  q_item_t           q_head;
  logic [SUM_W-1:0]  q_sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TEXT_WIDTH:   cfg.text_width   <= cfg_data[TW_REG_W-1:0];
        CFG_TEXT_HEIGHT:  cfg.text_height  <= cfg_data[TH_REG_W-1:0];
        CFG_WINDOW_WIDTH: cfg.window_width <= cfg_data[WW_REG_W-1:0];
        CFG_FADE_RED:     cfg.fade_red     <= cfg_data[CH_W-1:0];
        CFG_FADE_GREEN:   cfg.fade_green   <= cfg_data[CH_W-1:0];
        CFG_FADE_BLUE:    cfg.fade_blue    <= cfg_data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // effective text width, zero taken as one and clamped to the store
  always_comb begin
    if (cfg.text_width == '0) begin
      tw_eff = TW_W'(1);
    end else if (32'(cfg.text_width) > MAX_TEXT_WIDTH) begin
      tw_eff = TW_W'(MAX_TEXT_WIDTH);
    end else begin
      tw_eff = TW_W'(cfg.text_width);
    end
  end

  msef_front #(
    .MAX_TEXT_WIDTH  (MAX_TEXT_WIDTH),
    .MAX_TEXT_HEIGHT (MAX_TEXT_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .tw_eff     (tw_eff),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_full     (q_full),
    .q_push     (f_push),
    .q_item     (f_item),
    .q_sum      (f_sum)
  );

  msef_fifo #(
    .WIDTH (Q_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata ({f_sum, f_item}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign q_head = q_rdata[$bits(q_item_t)-1:0];
  assign q_sum  = q_rdata[Q_W-1:$bits(q_item_t)];

  msef_back #(
    .MAX_TEXT_WIDTH  (MAX_TEXT_WIDTH),
    .MAX_TEXT_HEIGHT (MAX_TEXT_HEIGHT),
    .FADE_WIDTH      (FADE_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .tw_eff       (tw_eff),
    .q_valid      (!q_empty),
    .q_head       (q_head),
    .q_sum        (q_sum),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

[hdl/msef_ram.sv]
module msef_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/msef_fifo.sv]
module msef_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

[hdl/msef_front.sv]
module msef_front import msef_pkg::*; #(
  parameter int MAX_TEXT_WIDTH  = DEF_MAX_TEXT_WIDTH,
  parameter int MAX_TEXT_HEIGHT = DEF_MAX_TEXT_HEIGHT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  cfg_t                                  cfg,
  input  logic [$clog2(MAX_TEXT_WIDTH):0]       tw_eff,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  item_t                                 item,
  input  logic                                  q_full,
  output logic                                  q_push,
  output q_item_t                               q_item,
  output logic [sum_width(MAX_TEXT_WIDTH)-1:0]  q_sum
);

  localparam int SCR_W = $clog2(MAX_TEXT_WIDTH);
  localparam int TW_W  = SCR_W + 1;
  localparam int SUM_W = sum_width(MAX_TEXT_WIDTH);
  localparam int CNT_W = $clog2(SCR_W + 1);

  localparam logic NRM_IDLE = 1'b0;
  localparam logic NRM_RUN  = 1'b1;

  logic             nrm_state;
  logic [CNT_W-1:0] nrm_cnt;
  logic [SCR_W-1:0] nrm_div;
  logic [SCR_W-1:0] nrm_rem;
  logic [SCR_W-1:0] rem_next;
  logic [TW_W-1:0]  nrm_t;
  logic [SCR_W-1:0] scroll;
  logic [SCR_W-1:0] scroll_tick;
  logic             not_yet_stepped;
  logic             need_norm;
  logic             accept;
  logic             is_write;

  // a tick that finds the scroll column beyond a shrunk text width
  // first reduces it by restoring division
  assign need_norm = item_valid && (item.operation == OP_TICK) &&
                     (TW_W'(scroll) >= tw_eff);
  assign item_stall = q_full || (nrm_state == NRM_RUN) || need_norm;
  assign accept = item_valid && !item_stall;

  always_comb begin
    nrm_t = {nrm_rem, nrm_div[SCR_W-1]};
    if (nrm_t >= tw_eff) begin
      nrm_t = nrm_t - tw_eff;
    end
    rem_next = nrm_t[SCR_W-1:0];
  end

  always_comb begin
    if (not_yet_stepped) begin
      scroll_tick = '0;
    end else if (TW_W'(scroll) + 1'b1 == tw_eff) begin
      scroll_tick = '0;
    end else begin
      scroll_tick = scroll + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nrm_state       <= NRM_IDLE;
      nrm_cnt         <= '0;
      scroll          <= '0;
      not_yet_stepped <= 1'b1;
    end else begin
      unique case (nrm_state)
        NRM_IDLE: begin
          if (need_norm) begin
            nrm_state <= NRM_RUN;
            nrm_div   <= scroll;
            nrm_rem   <= '0;
            nrm_cnt   <= '0;
          end else if (accept && item.operation == OP_TICK) begin
            scroll          <= scroll_tick;
            not_yet_stepped <= 1'b0;
          end
        end
        NRM_RUN: begin
          nrm_div <= nrm_div << 1;
          nrm_rem <= rem_next;
          nrm_cnt <= nrm_cnt + 1'b1;
          if (nrm_cnt == CNT_W'(SCR_W - 1)) begin
            scroll    <= rem_next;
            nrm_state <= NRM_IDLE;
          end
        end
        default: nrm_state <= NRM_IDLE;
      endcase
    end
  end

  assign is_write = (item.operation == OP_WRITE);
  assign q_push = accept && (is_write || item.operation == OP_READ);

  always_comb begin
    q_item.is_write = is_write;
    if (is_write) begin
      q_item.ok = (32'(item.column) < MAX_TEXT_WIDTH) && (32'(item.row) < MAX_TEXT_HEIGHT);
    end else begin
      q_item.ok = ({1'b0, item.row} < cfg.text_height) && (32'(item.row) < MAX_TEXT_HEIGHT);
    end
    q_item.column = item.column;
    q_item.row    = item.row;
    q_item.pixel  = {item.in_red, item.in_green, item.in_blue};
  end

  assign q_sum = SUM_W'(scroll) + SUM_W'(item.column);

endmodule

[hdl/msef_back.sv]
module msef_back import msef_pkg::*; #(
  parameter int MAX_TEXT_WIDTH  = DEF_MAX_TEXT_WIDTH,
  parameter int MAX_TEXT_HEIGHT = DEF_MAX_TEXT_HEIGHT,
  parameter int FADE_WIDTH      = DEF_FADE_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cfg_t                                 cfg,
  input  logic [$clog2(MAX_TEXT_WIDTH):0]      tw_eff,
  input  logic                                 q_valid,
  input  q_item_t                              q_head,
  input  logic [sum_width(MAX_TEXT_WIDTH)-1:0] q_sum,
  output logic                                 q_pop,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output result_t                              result
);

  localparam int SCR_W = $clog2(MAX_TEXT_WIDTH);
  localparam int TW_W  = SCR_W + 1;
  localparam int SUM_W = sum_width(MAX_TEXT_WIDTH);
  localparam int STEPS = 4;
  localparam int NM    = (SUM_W + STEPS - 1) / STEPS;
  localparam int DEPTH = MAX_TEXT_WIDTH * MAX_TEXT_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int PIX_W = 3 * CH_W;
  localparam int WGT_W = $clog2(FADE_WIDTH + 1);
  localparam int NUM_W = $clog2(FADE_WIDTH * CH_MAX + 1);
  localparam int RS    = NUM_W + 1;
  localparam int RM    = (1 << RS) / FADE_WIDTH;
  localparam int PW    = NUM_W + RS + 1;

  logic adv;

  // modulo stages
  logic             mv [NM+1];
  q_item_t          mi [NM+1];
  logic [SCR_W-1:0] mr [NM+1];
  logic [SUM_W-1:0] md [NM+1];
  logic [SCR_W-1:0] nr [NM];
  logic [SUM_W-1:0] nd [NM];

  // memory access
  logic [AW-1:0]    addr;
  logic [31:0]      col_sel;
  logic             ram_we;
  logic [PIX_W-1:0] ram_rdata;
  logic [WGT_W-1:0] wgt;
  logic [31:0]      ww;

  // blend stages
  logic             av;
  logic             a_ok;
  logic [WGT_W-1:0] a_wgt;
  logic [CH_W-1:0]  src_ch [3];
  logic [CH_W-1:0]  fade_ch [3];
  logic [WGT_W-1:0] fw;
  logic             bv;
  logic [NUM_W-1:0] b_num [3];
  logic [NUM_W-1:0] b_num_next [3];
  logic             cv;
  logic [NUM_W-1:0] c_num [3];
  logic [CH_W-1:0]  c_q0 [3];
  logic [CH_W-1:0]  c_q0_next [3];
  logic [CH_W-1:0]  q_fin [3];
  logic [NUM_W-1:0] c_rem [3];
  logic [PW-1:0]    prod [3];

  assign adv   = !result_valid || !result_stall;
  assign q_pop = adv && q_valid;

  for (genvar k = 0; k < NM; k++) begin : g_mod
    always_comb begin
      logic [SCR_W-1:0] r;
      logic [SUM_W-1:0] d;
      logic [TW_W-1:0]  t;
      r = mr[k];
      d = md[k];
      t = '0;
      for (int j = 0; j < STEPS; j++) begin
        if (k * STEPS + j < SUM_W) begin
          t = {r, d[SUM_W-1]};
          d = d << 1;
          if (t >= tw_eff) begin
            t = t - tw_eff;
          end
          r = t[SCR_W-1:0];
        end
      end
      nr[k] = r;
      nd[k] = d;
    end
  end

  assign col_sel = mi[NM].is_write ? 32'(mi[NM].column) : 32'(mr[NM]);
  assign addr    = AW'(32'(mi[NM].row) * MAX_TEXT_WIDTH + col_sel);
  assign ram_we  = adv && mv[NM] && mi[NM].is_write && mi[NM].ok;

  assign ww = (cfg.window_width == '0) ? 32'd1 : 32'(cfg.window_width);

  always_comb begin
    if (32'(mi[NM].column) < FADE_WIDTH) begin
      wgt = WGT_W'(mi[NM].column);
    end else if (32'(mi[NM].column) + FADE_WIDTH > ww) begin
      if (32'(mi[NM].column) >= ww) begin
        wgt = '0;
      end else begin
        wgt = WGT_W'(ww - 32'(mi[NM].column));
      end
    end else begin
      // full weight passes the source through
      wgt = WGT_W'(FADE_WIDTH);
    end
  end

  msef_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_pixels (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (mi[NM].pixel),
    .re    (adv),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    src_ch[0]  = a_ok ? ram_rdata[3*CH_W-1:2*CH_W] : '0;
    src_ch[1]  = a_ok ? ram_rdata[2*CH_W-1:CH_W] : '0;
    src_ch[2]  = a_ok ? ram_rdata[CH_W-1:0] : '0;
    fade_ch[0] = cfg.fade_red;
    fade_ch[1] = cfg.fade_green;
    fade_ch[2] = cfg.fade_blue;
    fw = WGT_W'(FADE_WIDTH) - a_wgt;
    for (int c = 0; c < 3; c++) begin
      b_num_next[c] = NUM_W'(a_wgt) * NUM_W'(src_ch[c]) + NUM_W'(fw) * NUM_W'(fade_ch[c]);
      prod[c] = PW'(b_num[c]) * PW'(RM);
      c_q0_next[c] = CH_W'(prod[c] >> RS);
      c_rem[c] = c_num[c] - NUM_W'(c_q0[c]) * NUM_W'(FADE_WIDTH);
      q_fin[c] = (c_rem[c] >= NUM_W'(FADE_WIDTH)) ? c_q0[c] + 1'b1 : c_q0[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NM; i++) begin
        mv[i] <= 1'b0;
      end
      av           <= 1'b0;
      bv           <= 1'b0;
      cv           <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      mv[0] <= q_valid;
      for (int i = 0; i < NM; i++) begin
        mv[i+1] <= mv[i];
      end
      av           <= mv[NM] && !mi[NM].is_write;
      bv           <= av;
      cv           <= bv;
      result_valid <= cv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mi[0] <= q_head;
      mr[0] <= '0;
      md[0] <= q_sum;
      for (int i = 0; i < NM; i++) begin
        mi[i+1] <= mi[i];
        mr[i+1] <= nr[i];
        md[i+1] <= nd[i];
      end
      a_ok  <= mi[NM].ok;
      a_wgt <= wgt;
      for (int c = 0; c < 3; c++) begin
        b_num[c] <= b_num_next[c];
        c_num[c] <= b_num[c];
        c_q0[c]  <= c_q0_next[c];
      end
      result.out_red   <= q_fin[0];
      result.out_green <= q_fin[1];
      result.out_blue  <= q_fin[2];
    end
  end

endmodule
